FILE: hw/rtl/tcon_pkg.sv
// ---------------------------------------------------------------------------
// Text console package
// Shared types, commands and character constants of the text console.
// ---------------------------------------------------------------------------
package tcon_pkg;

	localparam int SCREEN_COLS_DEF = 80;
	localparam int SCREEN_ROWS_DEF = 25;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_BLANK = 8'h20;

	typedef enum logic [2:0] {
		CMD_TTY      = 3'd0,
		CMD_SET_CUR  = 3'd1,
		CMD_GET_CUR  = 3'd2,
		CMD_SCR_UP   = 3'd3,
		CMD_SCR_DN   = 3'd4,
		CMD_READ     = 3'd5,
		CMD_WRITE    = 3'd6,
		CMD_TTY_POS  = 3'd7
	} cmd_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] char_code;
		logic [7:0] cell_attr;
		logic [7:0] row;
		logic [7:0] col;
		logic [7:0] bottom_row;
		logic [7:0] right_col;
		logic [7:0] line_count;
	} req_t;

	typedef struct packed {
		logic [7:0] cursor_row;
		logic [7:0] cursor_col;
		logic [7:0] char_out;
		logic [7:0] attr_out;
		logic       cell_valid;
	} rsp_t;

endpackage

FILE: hw/rtl/tcon_addr.sv
// ---------------------------------------------------------------------------
// Text console cell address unit
// Shared multiply-add that maps a row and column to a linear cell address.
// ---------------------------------------------------------------------------
module tcon_addr import tcon_pkg::*; #(
	parameter int SCREEN_COLS = SCREEN_COLS_DEF,
	parameter int AW          = 11
) (
	input  logic [7:0]    row,
	input  logic [7:0]    col,
	output logic [AW-1:0] addr
);

	logic [31:0] prod;

	assign prod = 32'(row) * 32'(SCREEN_COLS) + 32'(col);
	assign addr = prod[AW-1:0];

endmodule

FILE: hw/rtl/text_console_teletype_unit.sv
// ---------------------------------------------------------------------------
// Text console teletype unit
// Character/attribute screen with cursor, teletype and window scrolls.
// ---------------------------------------------------------------------------
// channel  direction  payload  handshake
// req      in         req_t    req_valid / req_stall
// rsp      out        rsp_t    rsp_valid / rsp_stall
//
// Cursor, get, set, off-screen and non-printing teletype commands go to S_DONE;
// read, write and printing teletype add a memory state. A scroll adds S_RD and
// S_WR per copied cell, S_FILL per filled cell and S_ROW per row, all through
// one address multiply-add and one memory port. After reset the screen memory
// is cleared before any command is taken. A stalled result is held while the
// next command runs; that command then waits until it is taken.
// ---------------------------------------------------------------------------
module text_console_teletype_unit import tcon_pkg::*; #(
	parameter int SCREEN_COLS = SCREEN_COLS_DEF,
	parameter int SCREEN_ROWS = SCREEN_ROWS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int         CELLS = SCREEN_ROWS * SCREEN_COLS;
	localparam int         AW    = $clog2(CELLS);
	localparam logic [7:0] LAST_ROW = 8'(SCREEN_ROWS - 1);
	localparam logic [7:0] LAST_COL = 8'(SCREEN_COLS - 1);
	localparam logic [8:0] ROWS9 = 9'(SCREEN_ROWS);
	localparam logic [8:0] COLS9 = 9'(SCREEN_COLS);

	typedef enum logic [8:0] {
		S_CLR   = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_ROW   = 9'b000000100,
		S_RD    = 9'b000001000,
		S_WR    = 9'b000010000,
		S_FILL  = 9'b000100000,
		S_STORE = 9'b001000000,
		S_READ  = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

	state_t state_q;

	logic [15:0]   mem [CELLS];
	logic [15:0]   rdata_q;
	logic [AW-1:0] clr_q;

	logic [7:0] cy_q, cx_q, cattr_q;
	logic [7:0] top_q, left_q, bot_q, right_q, y_q, x_q, fill_q;
	logic [8:0] eff_q;
	logic       down_q, copy_q, pend_q, rd_q;
	logic [7:0] sy_q, sx_q, st_char_q, st_attr_q;
	logic [7:0] res_attr_q;

	logic          out_valid_q;
	rsp_t          out_q;

	logic [7:0]    mrow, mcol, src_row;
	logic [AW-1:0] addr_f;
	logic          we;
	logic [AW-1:0] waddr;
	logic [15:0]   wdata;
	logic          re;

	tcon_addr #(.SCREEN_COLS(SCREEN_COLS), .AW(AW)) u_addr (
		.row(mrow), .col(mcol), .addr(addr_f)
	);

	assign src_row = down_q ? 8'({1'b0, y_q} - eff_q) : 8'({1'b0, y_q} + eff_q);

	always_comb begin
		mrow = y_q;
		mcol = x_q;
		unique case (state_q)
			S_RD:    mrow = src_row;
			S_STORE: begin mrow = sy_q; mcol = sx_q; end
			S_READ:  begin mrow = cy_q; mcol = cx_q; end
			default: ;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = addr_f;
		wdata = rdata_q;
		re    = (state_q == S_RD) || (state_q == S_READ);
		unique case (state_q)
			S_CLR:   begin we = 1'b1; waddr = clr_q; wdata = '0; end
			S_WR:    we = 1'b1;
			S_FILL:  begin we = 1'b1; wdata = {fill_q, CH_BLANK}; end
			S_STORE: begin we = 1'b1; wdata = {st_attr_q, st_char_q}; end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[addr_f];
	end

	// teletype decode
	logic [7:0] tx, ty, tat;
	logic [8:0] ty9, oy9;
	logic [7:0] ox;
	logic [7:0] tnx, tny;
	logic       tscr, tst;
	always_comb begin
		tx  = (req.cmd == CMD_TTY_POS) ? req.col : cx_q;
		ty  = (req.cmd == CMD_TTY_POS) ? req.row : cy_q;
		tat = (req.cmd == CMD_TTY_POS) ? req.cell_attr : cattr_q;
		ty9 = {1'b0, ty} + 9'd1;
		ox  = tx;
		oy9 = {1'b0, ty};
		tscr = 1'b0;
		tst  = 1'b0;
		tnx  = tx;
		tny  = ty;
		priority if (req.char_code == CH_CR) begin
			tnx = '0;
		end else if (req.char_code == CH_LF) begin
			tnx  = '0;
			tscr = ty9 >= ROWS9;
			tny  = tscr ? LAST_ROW : ty9[7:0];
		end else if (req.char_code == CH_BS) begin
			tnx = (tx != 8'd0) ? tx - 8'd1 : tx;
			tny = ({1'b0, ty} >= ROWS9) ? LAST_ROW : ty;
		end else begin
			if ({1'b0, tx} >= COLS9) begin
				ox  = '0;
				oy9 = ty9;
			end
			tscr = oy9 >= ROWS9;
			tst  = 1'b1;
			tny  = tscr ? LAST_ROW : oy9[7:0];
			tnx  = ox + 8'd1;
		end
	end

	// scroll window decode
	logic [7:0] botc, rightc;
	logic [8:0] h9, cnt9;
	logic       wempty;
	assign botc   = (req.bottom_row > LAST_ROW) ? LAST_ROW : req.bottom_row;
	assign rightc = (req.right_col > LAST_COL) ? LAST_COL : req.right_col;
	assign wempty = (req.row > botc) || (req.col > rightc);
	assign h9     = {1'b0, botc} - {1'b0, req.row} + 9'd1;
	assign cnt9   = {1'b0, req.line_count};

	logic on;
	assign on = ({1'b0, cx_q} < COLS9) && ({1'b0, cy_q} < ROWS9);

	logic last_col, last_row;
	assign last_col = (x_q == right_q);
	assign last_row = down_q ? (y_q == top_q) : (y_q == bot_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			cy_q        <= '0;
			cx_q        <= '0;
			cattr_q     <= '0;
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
			rd_q        <= 1'b0;
		end else begin
			if (out_valid_q && !rsp_stall && (state_q != S_DONE)) out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(CELLS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid) begin
						pend_q     <= 1'b0;
						rd_q       <= 1'b0;
						res_attr_q <= '0;
						state_q    <= S_DONE;
						unique case (req.cmd)
							CMD_TTY, CMD_TTY_POS: begin
								if (req.cmd == CMD_TTY_POS) cattr_q <= req.cell_attr;
								cx_q      <= tnx;
								cy_q      <= tny;
								pend_q    <= tst;
								sx_q      <= ox;
								sy_q      <= tny;
								st_char_q <= req.char_code;
								st_attr_q <= tat;
								top_q     <= '0;
								left_q    <= '0;
								bot_q     <= LAST_ROW;
								right_q   <= LAST_COL;
								eff_q     <= 9'd1;
								down_q    <= 1'b0;
								fill_q    <= tat;
								y_q       <= '0;
								if (tscr) state_q <= S_ROW;
								else if (tst) state_q <= S_STORE;
							end
							CMD_SET_CUR: begin
								cy_q <= req.row;
								cx_q <= req.col;
							end
							CMD_GET_CUR: res_attr_q <= cattr_q;
							CMD_SCR_UP, CMD_SCR_DN: begin
								cy_q    <= req.row;
								cx_q    <= req.col;
								top_q   <= req.row;
								left_q  <= req.col;
								bot_q   <= botc;
								right_q <= rightc;
								down_q  <= (req.cmd == CMD_SCR_DN);
								eff_q   <= (cnt9 == 9'd0 || cnt9 >= h9) ? h9 : cnt9;
								fill_q  <= req.cell_attr;
								y_q     <= (req.cmd == CMD_SCR_DN) ? botc : req.row;
								if (!wempty) state_q <= S_ROW;
							end
							CMD_READ: begin
								if (on) begin
									rd_q    <= 1'b1;
									state_q <= S_READ;
								end
							end
							CMD_WRITE: begin
								sy_q      <= cy_q;
								sx_q      <= cx_q;
								st_char_q <= req.char_code;
								st_attr_q <= req.cell_attr;
								if (cx_q < LAST_COL) cx_q <= cx_q + 8'd1;
								if (on) state_q <= S_STORE;
							end
							default: ;
						endcase
					end
				end
				S_ROW: begin
					x_q    <= left_q;
					copy_q <= down_q ? ({1'b0, y_q} >= {1'b0, top_q} + eff_q)
					                 : ({1'b0, y_q} + eff_q <= {1'b0, bot_q});
					state_q <= (down_q ? ({1'b0, y_q} >= {1'b0, top_q} + eff_q)
					                   : ({1'b0, y_q} + eff_q <= {1'b0, bot_q}))
					           ? S_RD : S_FILL;
				end
				S_RD: state_q <= S_WR;
				S_WR, S_FILL: begin
					if (!last_col) begin
						x_q     <= x_q + 8'd1;
						state_q <= copy_q ? S_RD : S_FILL;
					end else if (!last_row) begin
						y_q     <= down_q ? y_q - 8'd1 : y_q + 8'd1;
						state_q <= S_ROW;
					end else begin
						state_q <= pend_q ? S_STORE : S_DONE;
					end
				end
				S_STORE: state_q <= S_DONE;
				S_READ:  state_q <= S_DONE;
				S_DONE: begin
					if (!out_valid_q || !rsp_stall) begin
						out_valid_q      <= 1'b1;
						out_q.cursor_row <= cy_q;
						out_q.cursor_col <= cx_q;
						out_q.char_out   <= rd_q ? rdata_q[7:0] : 8'd0;
						out_q.attr_out   <= rd_q ? rdata_q[15:8] : res_attr_q;
						out_q.cell_valid <= rd_q;
						state_q          <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule
